@@ design/kcs_pkg.sv @@
// ----------------------------------------------------------------------------
// kcs_pkg
// shared types and constants for the keyword caesar substitution block
// ----------------------------------------------------------------------------
`default_nettype none

package kcs_pkg;

    localparam int ALPHA      = 26;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 60;
    localparam int LETTER_W   = 5;
    localparam int LOW_BITS   = 60;
    localparam int MID_BITS   = 60;
    localparam int HIGH_BITS  = 10;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [LETTER_W-1:0]  t_letter;

    localparam t_cfg_idx CFG_SHIFT    = 3'd0;
    localparam t_cfg_idx CFG_DECRYPT  = 3'd1;
    localparam t_cfg_idx CFG_KEY_LEN  = 3'd2;
    localparam t_cfg_idx CFG_KEY_LOW  = 3'd3;
    localparam t_cfg_idx CFG_KEY_MID  = 3'd4;
    localparam t_cfg_idx CFG_KEY_HIGH = 3'd5;

    localparam logic [7:0] LOWER_A   = 8'd97;
    localparam logic [7:0] LOWER_END = 8'd123;

    typedef struct packed {
        logic start;
        logic hold;
        logic key_step;
        logic fill_step;
        logic load_out;
        logic sel_held;
    } t_cmd;

    typedef struct packed {
        logic cfg_hit;
        logic key_done;
        logic fill_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

@@ design/keyword_caesar_substitution_top.sv @@
// ----------------------------------------------------------------------------
// keyword_caesar_substitution_top
// keyword caesar substitution on a byte stream
// ----------------------------------------------------------------------------
// Once the cipher tables are built, one byte is taken per cycle while the
// output register is free, and its result appears in the output register
// on the next cycle. The first byte after reset or after a write to config
// index 0 to 5 starts a table build run by the sequencer, which walks the
// first key_length key letters (clamped to MAX_KEY_LETTERS), then a to z,
// placing each letter not yet used. Lowercase a to z are mapped through the
// forward or inverse table, all other bytes pass through unchanged.
`default_nettype none

module keyword_caesar_substitution_top #(
    parameter int MAX_KEY_LETTERS = 26
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_wen,
    input  wire [kcs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [kcs_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire [7:0]                       s_axis_tdata,   // text_byte
    input  wire                             s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    output logic [7:0]                      m_axis_tdata,   // out_byte
    output logic                            m_axis_tlast
);

    kcs_pkg::t_cmd w_cmd;
    kcs_pkg::t_sts w_sts;

    kcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (w_sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    kcs_datapath #(
        .MAX_KEY_LETTERS (MAX_KEY_LETTERS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_byte   (s_axis_tdata),
        .i_in_last   (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (m_axis_tvalid),
        .o_out_byte  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

@@ design/kcs_datapath.sv @@
// ----------------------------------------------------------------------------
// kcs_datapath
// config registers, table build counters, cipher tables and output register
// ----------------------------------------------------------------------------
`default_nettype none

module kcs_datapath #(
    parameter int MAX_KEY_LETTERS = 26
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_wen,
    input  wire kcs_pkg::t_cfg_idx           i_cfg_idx,
    input  wire [kcs_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  wire [7:0]                        i_in_byte,
    input  wire                              i_in_last,
    input  wire                              i_out_ready,
    input  wire kcs_pkg::t_cmd               i_cmd,
    output kcs_pkg::t_sts                    o_sts,
    output logic                             o_out_valid,
    output logic [7:0]                       o_out_byte,
    output logic                             o_out_last
);

    localparam int KeyBits  = MAX_KEY_LETTERS * kcs_pkg::LETTER_W;
    localparam int FullBits = kcs_pkg::LOW_BITS + kcs_pkg::MID_BITS + kcs_pkg::HIGH_BITS;
    localparam int KeyCntW  = $clog2(MAX_KEY_LETTERS + 1);
    localparam int KeyIdxW  = (MAX_KEY_LETTERS > 1) ? $clog2(MAX_KEY_LETTERS) : 1;

    logic [4:0]          r_shift;
    logic                r_decrypt;
    logic [4:0]          r_key_len;
    logic [KeyBits-1:0]  r_key;
    logic [KeyBits-1:0]  n_key;
    logic [FullBits-1:0] w_rep;

    logic [KeyCntW-1:0]  r_ki;
    logic [4:0]          r_fc;
    logic [4:0]          r_pos;
    logic [25:0]         r_used;

    kcs_pkg::t_letter    r_fwd [kcs_pkg::ALPHA];
    kcs_pkg::t_letter    r_inv [kcs_pkg::ALPHA];
    kcs_pkg::t_letter    w_letter [MAX_KEY_LETTERS];

    logic [7:0]          r_hold_byte;
    logic                r_hold_last;
    logic                r_out_valid;
    logic [7:0]          r_out_byte;
    logic                r_out_last;

    logic [KeyCntW-1:0]  w_len;
    logic [4:0]          w_pos0;
    logic [4:0]          w_pos_inc;
    kcs_pkg::t_letter    w_key_c;
    logic                w_key_new;
    logic                w_we;
    kcs_pkg::t_letter    w_wc;
    logic [7:0]          w_src;
    logic                w_is_low;
    logic [4:0]          w_idx;
    kcs_pkg::t_letter    w_entry;
    logic [7:0]          w_map;
    logic                w_cfg_hit;

    // config write decode
    assign w_cfg_hit = i_cfg_wen && (i_cfg_idx <= kcs_pkg::CFG_KEY_HIGH);
    assign w_rep = {i_cfg_wdata[kcs_pkg::HIGH_BITS-1:0], i_cfg_wdata, i_cfg_wdata};

    always_comb begin
        n_key = r_key;
        for (int k = 0; k < KeyBits; k++) begin
            if (k < kcs_pkg::LOW_BITS) begin
                if (i_cfg_wen && i_cfg_idx == kcs_pkg::CFG_KEY_LOW) n_key[k] = w_rep[k];
            end else if (k < kcs_pkg::LOW_BITS + kcs_pkg::MID_BITS) begin
                if (i_cfg_wen && i_cfg_idx == kcs_pkg::CFG_KEY_MID) n_key[k] = w_rep[k];
            end else begin
                if (i_cfg_wen && i_cfg_idx == kcs_pkg::CFG_KEY_HIGH) n_key[k] = w_rep[k];
            end
        end
    end

    for (genvar j = 0; j < MAX_KEY_LETTERS; j++) begin : g_letter
        assign w_letter[j] = r_key[j*kcs_pkg::LETTER_W +: kcs_pkg::LETTER_W];
    end

    // build step
    assign w_len     = (r_key_len > 5'(MAX_KEY_LETTERS)) ? KeyCntW'(MAX_KEY_LETTERS)
                                                          : r_key_len[KeyCntW-1:0];
    assign w_pos0    = (r_shift >= 5'(kcs_pkg::ALPHA)) ? r_shift - 5'(kcs_pkg::ALPHA)
                                                       : r_shift;
    assign w_pos_inc = (r_pos == 5'(kcs_pkg::ALPHA - 1)) ? 5'd0 : r_pos + 5'd1;
    assign w_key_c   = w_letter[r_ki[KeyIdxW-1:0]];
    assign w_key_new = (w_key_c < 5'(kcs_pkg::ALPHA)) && !r_used[w_key_c];
    assign w_we      = (i_cmd.key_step && w_key_new) || (i_cmd.fill_step && !r_used[r_fc]);
    assign w_wc      = i_cmd.fill_step ? r_fc : w_key_c;

    // byte lookup
    assign w_src    = i_cmd.sel_held ? r_hold_byte : i_in_byte;
    assign w_is_low = (w_src >= kcs_pkg::LOWER_A) && (w_src < kcs_pkg::LOWER_END);
    assign w_idx    = 5'(w_src - kcs_pkg::LOWER_A);
    assign w_entry  = r_decrypt ? r_inv[w_idx] : r_fwd[w_idx];
    assign w_map    = w_is_low ? kcs_pkg::LOWER_A + {3'b000, w_entry} : w_src;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift     <= 5'd1;
            r_decrypt   <= 1'b0;
            r_key_len   <= 5'd0;
            r_key       <= '0;
            r_ki        <= '0;
            r_fc        <= 5'd0;
            r_pos       <= 5'd0;
            r_used      <= 26'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_key <= n_key;
            if (i_cfg_wen && i_cfg_idx == kcs_pkg::CFG_SHIFT)   r_shift   <= i_cfg_wdata[4:0];
            if (i_cfg_wen && i_cfg_idx == kcs_pkg::CFG_DECRYPT) r_decrypt <= i_cfg_wdata[0];
            if (i_cfg_wen && i_cfg_idx == kcs_pkg::CFG_KEY_LEN) r_key_len <= i_cfg_wdata[4:0];
            if (i_cmd.start) begin
                r_ki   <= '0;
                r_fc   <= 5'd0;
                r_pos  <= w_pos0;
                r_used <= 26'd0;
            end else begin
                if (i_cmd.key_step) r_ki <= r_ki + KeyCntW'(1);
                if (i_cmd.fill_step) r_fc <= r_fc + 5'd1;
                if (w_we) begin
                    r_pos        <= w_pos_inc;
                    r_used[w_wc] <= 1'b1;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we && !i_cmd.start) begin
            r_fwd[r_pos] <= w_wc;
            r_inv[w_wc]  <= r_pos;
        end
        if (i_cmd.hold) begin
            r_hold_byte <= i_in_byte;
            r_hold_last <= i_in_last;
        end
        if (i_cmd.load_out) begin
            r_out_byte <= w_map;
            r_out_last <= i_cmd.sel_held ? r_hold_last : i_in_last;
        end
    end

    assign o_sts.cfg_hit   = w_cfg_hit;
    assign o_sts.key_done  = (r_ki >= w_len);
    assign o_sts.fill_last = (r_fc == 5'(kcs_pkg::ALPHA - 1));
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

endmodule

`default_nettype wire

@@ design/kcs_ctrl.sv @@
// ----------------------------------------------------------------------------
// kcs_ctrl
// sequencer for table build and byte handoff
// ----------------------------------------------------------------------------
`default_nettype none

module kcs_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire kcs_pkg::t_sts  i_sts,
    output logic                o_in_ready,
    output kcs_pkg::t_cmd       o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_KEY  = 2'd1;
    localparam logic [1:0] ST_FILL = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_tbl_ok;
    logic       n_tbl_ok;
    logic       w_accept;

    assign o_in_ready = (r_state == ST_IDLE) && i_sts.out_free;
    assign w_accept   = o_in_ready && i_in_valid;

    always_comb begin
        n_state  = r_state;
        n_tbl_ok = r_tbl_ok;
        o_cmd    = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (r_tbl_ok) begin
                        o_cmd.load_out = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        o_cmd.hold  = 1'b1;
                        n_state     = ST_KEY;
                    end
                end
            end
            ST_KEY: begin
                if (i_sts.key_done) begin
                    n_state = ST_FILL;
                end else begin
                    o_cmd.key_step = 1'b1;
                end
            end
            ST_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_sts.fill_last) begin
                    n_tbl_ok = 1'b1;
                    n_state  = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.sel_held = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (i_sts.cfg_hit) n_tbl_ok = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_tbl_ok <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_tbl_ok <= n_tbl_ok;
        end
    end

endmodule

`default_nettype wire

@@ design/kcs_checker.sv @@
// ----------------------------------------------------------------------------
// kcs_checker
// port-level checks for the keyword caesar substitution block
// ----------------------------------------------------------------------------
`default_nettype none

module kcs_checker (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire                             s_axis_tvalid,
    input wire                             s_axis_tready,
    input wire [7:0]                       s_axis_tdata,
    input wire                             s_axis_tlast,
    input wire                             m_axis_tvalid,
    input wire                             m_axis_tready,
    input wire [7:0]                       m_axis_tdata,
    input wire                             m_axis_tlast
);

    // output register empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output beat valid after reset");

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output beat changed");

    // no input beat taken while the output register is blocked
    a_no_accept_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready && m_axis_tvalid |-> m_axis_tready)
        else $error("input taken with output stalled");

    // non-letter bytes come out unchanged
    a_pass_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tdata < 8'd97 || s_axis_tdata > 8'd122)
        |=> !m_axis_tvalid ||
            (m_axis_tdata == $past(s_axis_tdata) && m_axis_tlast == $past(s_axis_tlast)))
        else $error("non-letter byte altered");

endmodule

bind keyword_caesar_substitution_top kcs_checker u_kcs_checker (.*);

`default_nettype wire
